// ----- sv/epwm_pkg.sv -----
// shared constants and types for the encoder pulse width meter
// no dependencies; imported by the top level and the testbench

package epwm_pkg;

    // default sizes of the capture counter and of the measured lengths
    localparam int COUNT_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 20;

    // fixed field widths
    localparam int WEIGHT_BITS = 17;
    localparam int WRAP_BITS   = 4;
    localparam int GLITCH_BITS = 16;
    localparam int SPEED_BITS  = 24;
    localparam int DUTY_BITS   = 17;
    localparam int DUTY_FRAC   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // divider: dividend bits shifted in, step counter
    localparam int DIV_BITS     = SPEED_BITS;
    localparam int DIV_CNT_BITS = 5;

    // register reset values
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST  = 17'd65535;
    localparam logic [WRAP_BITS-1:0]   MAX_OVF_RST = 4'd5;
    localparam logic [GLITCH_BITS-1:0] GLITCH_RST  = 16'd20;
    localparam logic [SPEED_BITS-1:0]  NUMER_RST   = 24'd7500000;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OVERFLOW_WEIGHT = 2'd0,
        CFG_MAX_OVERFLOWS   = 2'd1,
        CFG_GLITCH_LIMIT    = 2'd2,
        CFG_SPEED_NUMERATOR = 2'd3
    } t_cfg_idx;

    // event kinds
    localparam logic ACT_CAPTURE  = 1'b0;
    localparam logic ACT_OVERFLOW = 1'b1;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_EXTEND    = 6'b000010,
        ST_SPEED_DIV = 6'b000100,
        ST_UPDATE    = 6'b001000,
        ST_DUTY_DIV  = 6'b010000,
        ST_DONE      = 6'b100000
    } t_state;

endpackage

// ----- sv/encoder_pulse_width_meter_top.sv -----
// encoder pulse width meter: input capture tachometer with a shared serial divider
// depends on epwm_pkg
//
// sequence: overflow words and captures that report no width pass the extend and
//   done states before o_m_tvalid rises; an accepted width also passes the speed
//   divide (rising edge, nonzero old period), update and duty divide states
// flow: one word at a time, the next word is taken once the last one's result is
//   registered; the single restoring divider is shared, and a held result stalls input
// reset: i_rst_n low at a clock edge clears all but payload, loads register defaults

module encoder_pulse_width_meter_top #(
    parameter int COUNT_BITS  = epwm_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = epwm_pkg::LENGTH_BITS_DEF,
    localparam int IN_W        = COUNT_BITS + 1,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 4 * LENGTH_BITS + 1 + epwm_pkg::SPEED_BITS
                               + epwm_pkg::DUTY_BITS + 2,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: capture_count, pin_level, zero pad
    input  logic [IN_TDATA_W-1:0]              i_s_tdata,
    // tuser: action
    input  logic                               i_s_tuser,
    // result words
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: width, high_length, low_length, period, speed, duty, armed,
    // timed_out, zero pad
    output logic [OUT_TDATA_W-1:0]             o_m_tdata,
    // tuser: width_valid
    output logic                               o_m_tuser,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [epwm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [epwm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    import epwm_pkg::*;

    localparam int PER_BITS  = LENGTH_BITS + 1;
    localparam int PROD_BITS = WEIGHT_BITS + WRAP_BITS;
    localparam int EXT_BITS  = ((COUNT_BITS > PROD_BITS) ? COUNT_BITS : PROD_BITS) + 1;
    localparam int CMP_BITS  = (EXT_BITS > LENGTH_BITS) ? EXT_BITS : LENGTH_BITS;
    localparam int PAD_IN    = IN_TDATA_W - IN_W;
    localparam int PAD_OUT   = OUT_TDATA_W - OUT_W;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0]   DUTY_ONE = DUTY_BITS'(1) << DUTY_FRAC;

    // configuration registers
    logic [WEIGHT_BITS-1:0] r_weight;
    logic [WRAP_BITS-1:0]   r_max_ovf;
    logic [GLITCH_BITS-1:0] r_glitch;
    logic [SPEED_BITS-1:0]  r_numer;

    // sequencer and measurement state
    t_state                 r_state, n_state;
    logic                   r_running, n_running;
    logic [WRAP_BITS-1:0]   r_wrap, n_wrap;
    logic [LENGTH_BITS-1:0] r_high, n_high;
    logic [LENGTH_BITS-1:0] r_low, n_low;
    logic [PER_BITS-1:0]    r_period, n_period;
    logic [SPEED_BITS-1:0]  r_speed, n_speed;
    logic [DUTY_BITS-1:0]   r_duty, n_duty;
    logic                   r_out_valid, n_out_valid;

    // per-word working registers
    logic                   r_act, n_act;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic                   r_pin, n_pin;
    logic [LENGTH_BITS-1:0] r_w, n_w;
    logic                   r_wvalid, n_wvalid;
    logic                   r_tout, n_tout;

    // shared restoring divider
    logic [PER_BITS-1:0]     r_rem, n_rem;
    logic [DIV_BITS-1:0]     r_dbits, n_dbits;
    logic [DIV_BITS-1:0]     r_quo, n_quo;
    logic [DIV_CNT_BITS-1:0] r_dcnt, n_dcnt;

    // output word register
    logic [OUT_W-1:0] r_out_data, n_out_data;
    logic             r_out_user, n_out_user;

    logic                   s_accept;
    logic                   m_accept;
    logic [CMP_BITS-1:0]    ext_sum;
    logic [LENGTH_BITS-1:0] ext_w;
    logic [PER_BITS:0]      div_shift;
    logic                   div_ge;
    logic [PER_BITS-1:0]    div_rem_next;
    logic [DIV_BITS-1:0]    div_quo_next;
    logic [LENGTH_BITS-1:0] upd_high;
    logic [LENGTH_BITS-1:0] upd_low;
    logic [PER_BITS-1:0]    upd_period;
    logic [WRAP_BITS-1:0]   wrap_inc;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign m_accept    = r_out_valid && i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = {{PAD_OUT{1'b0}}, r_out_data};

    // count plus weighted overflows, saturated to the length width
    assign ext_sum = CMP_BITS'(r_count)
                   + CMP_BITS'(CMP_BITS'(r_weight) * CMP_BITS'(r_wrap));
    assign ext_w   = (ext_sum > CMP_BITS'(LEN_MAX)) ? LEN_MAX : ext_sum[LENGTH_BITS-1:0];

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign div_shift    = {r_rem, r_dbits[DIV_BITS-1]};
    assign div_ge       = (div_shift >= {1'b0, r_period});
    assign div_rem_next = div_ge ? PER_BITS'(div_shift - {1'b0, r_period})
                                 : div_shift[PER_BITS-1:0];
    assign div_quo_next = {r_quo[DIV_BITS-2:0], div_ge};

    // new lengths after an accepted width
    assign upd_high   = r_pin ? r_high : r_w;
    assign upd_low    = r_pin ? r_w : r_low;
    assign upd_period = PER_BITS'(upd_high) + PER_BITS'(upd_low);

    assign wrap_inc = r_wrap + WRAP_BITS'(1);

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_wrap      = r_wrap;
        n_high      = r_high;
        n_low       = r_low;
        n_period    = r_period;
        n_speed     = r_speed;
        n_duty      = r_duty;
        n_out_valid = r_out_valid;
        n_act       = r_act;
        n_count     = r_count;
        n_pin       = r_pin;
        n_w         = r_w;
        n_wvalid    = r_wvalid;
        n_tout      = r_tout;
        n_rem       = r_rem;
        n_dbits     = r_dbits;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (m_accept) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_act   = i_s_tuser;
                    n_count = i_s_tdata[COUNT_BITS-1:0];
                    n_pin   = i_s_tdata[COUNT_BITS];
                    n_state = ST_EXTEND;
                end
            end
            ST_EXTEND: begin
                n_w      = '0;
                n_wvalid = 1'b0;
                n_tout   = 1'b0;
                n_state  = ST_DONE;
                if (r_act == ACT_OVERFLOW) begin
                    if (r_running) begin
                        n_wrap = wrap_inc;
                        if (wrap_inc >= r_max_ovf) begin
                            n_wrap    = '0;
                            n_running = 1'b0;
                            n_tout    = 1'b1;
                        end
                    end
                end else if (r_running) begin
                    n_w    = ext_w;
                    n_wrap = '0;
                    if (ext_w > LENGTH_BITS'(r_glitch)) begin
                        n_wvalid = 1'b1;
                        n_state  = ST_UPDATE;
                        if (r_pin) begin
                            // speed uses the period from before this edge
                            if (r_period == '0) begin
                                n_speed = '0;
                            end else begin
                                n_rem   = '0;
                                n_dbits = r_numer;
                                n_quo   = '0;
                                n_dcnt  = DIV_CNT_BITS'(SPEED_BITS);
                                n_state = ST_SPEED_DIV;
                            end
                        end
                    end
                end else if (r_pin) begin
                    n_running = 1'b1;
                    n_wrap    = '0;
                end
            end
            ST_SPEED_DIV: begin
                n_rem   = div_rem_next;
                n_dbits = {r_dbits[DIV_BITS-2:0], 1'b0};
                n_quo   = div_quo_next;
                n_dcnt  = r_dcnt - DIV_CNT_BITS'(1);
                if (r_dcnt == DIV_CNT_BITS'(1)) begin
                    n_speed = div_quo_next[SPEED_BITS-1:0];
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_high   = upd_high;
                n_low    = upd_low;
                n_period = upd_period;
                if (upd_period == '0) begin
                    n_duty  = '0;
                    n_state = ST_DONE;
                end else begin
                    // high <= period keeps the quotient within 17 bits, so the
                    // division starts with the top dividend bits already in
                    n_rem   = PER_BITS'(upd_high >> 1);
                    n_dbits = {upd_high[0], {(DIV_BITS-1){1'b0}}};
                    n_quo   = '0;
                    n_dcnt  = DIV_CNT_BITS'(DUTY_BITS);
                    n_state = ST_DUTY_DIV;
                end
            end
            ST_DUTY_DIV: begin
                n_rem   = div_rem_next;
                n_dbits = {r_dbits[DIV_BITS-2:0], 1'b0};
                n_quo   = div_quo_next;
                n_dcnt  = r_dcnt - DIV_CNT_BITS'(1);
                if (r_dcnt == DIV_CNT_BITS'(1)) begin
                    n_duty  = div_quo_next[DUTY_BITS-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for room in the output register
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_wvalid;
                    n_out_data  = {r_tout, r_running, r_duty, r_speed, r_period,
                                   r_low, r_high, r_w};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= 1'b0;
            r_wrap      <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_period    <= '0;
            r_speed     <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_wrap      <= n_wrap;
            r_high      <= n_high;
            r_low       <= n_low;
            r_period    <= n_period;
            r_speed     <= n_speed;
            r_duty      <= n_duty;
            r_out_valid <= n_out_valid;
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= WEIGHT_RST;
            r_max_ovf <= MAX_OVF_RST;
            r_glitch  <= GLITCH_RST;
            r_numer   <= NUMER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OVERFLOW_WEIGHT: r_weight  <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_MAX_OVERFLOWS:   r_max_ovf <= i_cfg_data[WRAP_BITS-1:0];
                CFG_GLITCH_LIMIT:    r_glitch  <= i_cfg_data[GLITCH_BITS-1:0];
                CFG_SPEED_NUMERATOR: r_numer   <= i_cfg_data[SPEED_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_count    <= n_count;
        r_pin      <= n_pin;
        r_w        <= n_w;
        r_wvalid   <= n_wvalid;
        r_tout     <= n_tout;
        r_rem      <= n_rem;
        r_dbits    <= n_dbits;
        r_quo      <= n_quo;
        r_dcnt     <= n_dcnt;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // input padding bits carry nothing
    if (PAD_IN > 0) begin : g_pad_in
        logic unused_pad;
        assign unused_pad = ^i_s_tdata[IN_TDATA_W-1:IN_W];
    end

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input accepted while a word is in progress");

    // a timeout always leaves the meter disarmed
    a_timeout_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[OUT_W-1]) |-> !r_out_data[OUT_W-2])
        else $error("timed out but still armed");

    // duty never exceeds one in Q16
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_duty <= DUTY_ONE))
        else $error("duty above one");

    // period tracks the two lengths once a width is taken
    a_period_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_period == PER_BITS'(r_high) + PER_BITS'(r_low)))
        else $error("period differs from high plus low");

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for encoder_pulse_width_meter_top
// depends on epwm_pkg and the block's rtl; a local tachometer model predicts each result word

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import epwm_pkg::*;

    // bus widths as the top level derives them for the default sizes
    localparam int CNT_W       = COUNT_BITS_DEF;
    localparam int LEN_W       = LENGTH_BITS_DEF;
    localparam int IN_TDATA_W  = ((CNT_W + 1 + 7) / 8) * 8;
    localparam int OUT_W       = 4 * LEN_W + 1 + SPEED_BITS + DUTY_BITS + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // settle time covers the longest word's pass through the sequencer, with slack on top
    localparam int SETTLE_CYCLES = 80;
    // hang limit, well above the slowest legal run
    localparam int CYCLE_LIMIT   = 400000;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 1;

    // one result word, field by field
    typedef struct {
        logic                   width_valid;
        logic [LEN_W-1:0]       width;
        logic [LEN_W-1:0]       high_len;
        logic [LEN_W-1:0]       low_len;
        logic [LEN_W:0]         period;
        logic [SPEED_BITS-1:0]  speed;
        logic [DUTY_BITS-1:0]   duty;
        logic                   armed;
        logic                   timed_out;
    } t_meter_reading;

    // dut signals; the inputs driven here are known from time zero
    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata   = '0;
    logic                     i_s_tuser   = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // model copy of the registers, loaded with the reset defaults
    logic [WEIGHT_BITS-1:0]   cfg_weight  = WEIGHT_RST;
    logic [WRAP_BITS-1:0]     cfg_max_ovf = MAX_OVF_RST;
    logic [GLITCH_BITS-1:0]   cfg_glitch  = GLITCH_RST;
    logic [SPEED_BITS-1:0]    cfg_numer   = NUMER_RST;

    // model copy of the measurement state
    logic                     st_running = 1'b0;
    logic [WRAP_BITS-1:0]     st_wraps   = '0;
    logic [LEN_W-1:0]         st_high    = '0;
    logic [LEN_W-1:0]         st_low     = '0;
    logic [LEN_W:0]           st_period  = '0;
    logic [SPEED_BITS-1:0]    st_speed   = '0;
    logic [DUTY_BITS-1:0]     st_duty    = '0;

    t_meter_reading pending_readings[$];
    int  mismatch_count = 0;
    int  live_events    = 0;   // words the meter did not just ignore
    int  holdoff_left   = 0;   // receiver back-pressure stretch, counted down per cycle
    bit  calm_mode      = 1'b0; // no idling on either side while set

    encoder_pulse_width_meter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // tachometer model: advance the state by one event, return the word it produces
    function automatic t_meter_reading meter_predict(logic act, logic [CNT_W-1:0] count,
                                                     logic pin);
        t_meter_reading   r;
        longint unsigned  ext;
        longint unsigned  q16;
        r.width_valid = 1'b0;
        r.width       = '0;
        r.timed_out   = 1'b0;
        if (act == ACT_CAPTURE) begin
            if (st_running) begin
                // extend the latched count by the overflows seen since the last edge
                ext = 64'(count) + 64'(cfg_weight) * 64'(st_wraps);
                if (ext > LEN_MAX) ext = LEN_MAX;
                r.width  = ext[LEN_W-1:0];
                st_wraps = '0;
                if (ext > 64'(cfg_glitch)) begin
                    r.width_valid = 1'b1;
                    if (pin) begin
                        // rising edge ends a low level; speed uses the old period
                        st_low   = ext[LEN_W-1:0];
                        st_speed = (st_period == 0) ? '0
                                 : cfg_numer / SPEED_BITS'(st_period);
                    end else begin
                        st_high = ext[LEN_W-1:0];
                    end
                    st_period = (LEN_W+1)'(st_high) + (LEN_W+1)'(st_low);
                    q16 = longint'(st_high) << DUTY_FRAC;
                    if (st_period == 0) st_duty = '0;
                    else begin
                        q16     = q16 / 64'(st_period);
                        st_duty = q16[DUTY_BITS-1:0];
                    end
                end
            end else if (pin) begin
                // a high pin arms the meter
                st_running = 1'b1;
                st_wraps   = '0;
            end
        end else if (st_running) begin
            st_wraps = st_wraps + WRAP_BITS'(1);
            if (st_wraps >= cfg_max_ovf) begin
                st_wraps    = '0;
                st_running  = 1'b0;
                r.timed_out = 1'b1;
            end
        end
        r.high_len = st_high;
        r.low_len  = st_low;
        r.period   = st_period;
        r.speed    = st_speed;
        r.duty     = st_duty;
        r.armed    = st_running;
        return r;
    endfunction

    // offer one event word, with random idle cycles ahead of it, and record its prediction
    task automatic send_event(logic act, logic [CNT_W-1:0] count, logic pin);
        bit was_running;
        while (!calm_mode && $urandom_range(99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - CNT_W - 1){1'b0}}, pin, count};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        // accepted at this edge
        was_running = st_running;
        pending_readings.push_back(meter_predict(act, count, pin));
        if (was_running || st_running) live_events++;
    endtask

    // stop offering, let every expected word arrive, then let the block settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write on the config channel; valid is lowered by the caller
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OVERFLOW_WEIGHT: cfg_weight  = data[WEIGHT_BITS-1:0];
            CFG_MAX_OVERFLOWS:   cfg_max_ovf = data[WRAP_BITS-1:0];
            CFG_GLITCH_LIMIT:    cfg_glitch  = data[GLITCH_BITS-1:0];
            CFG_SPEED_NUMERATOR: cfg_numer   = data[SPEED_BITS-1:0];
            default: ;
        endcase
    endtask

    // rewrite all four registers with the block idle
    task automatic set_registers(logic [CFG_DATA_BITS-1:0] weight,
                                 logic [CFG_DATA_BITS-1:0] max_ovf,
                                 logic [CFG_DATA_BITS-1:0] glitch,
                                 logic [CFG_DATA_BITS-1:0] numer);
        wait_idle();
        write_reg(CFG_OVERFLOW_WEIGHT, weight);
        write_reg(CFG_MAX_OVERFLOWS, max_ovf);
        write_reg(CFG_GLITCH_LIMIT, glitch);
        write_reg(CFG_SPEED_NUMERATOR, numer);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // compare one accepted result word with the oldest prediction
    task automatic check_reading();
        t_meter_reading e;
        if (pending_readings.size() == 0) begin
            $error("result word with nothing expected");
            mismatch_count++;
        end else begin
            e = pending_readings.pop_front();
            // tdata: width, high, low, period, speed, duty, armed, timed_out from bit 0
            check_field("width_valid", 64'(e.width_valid), 64'(o_m_tuser));
            check_field("width",       64'(e.width),       64'(o_m_tdata[19:0]));
            check_field("high_length", 64'(e.high_len),    64'(o_m_tdata[39:20]));
            check_field("low_length",  64'(e.low_len),     64'(o_m_tdata[59:40]));
            check_field("period",      64'(e.period),      64'(o_m_tdata[80:60]));
            check_field("speed",       64'(e.speed),       64'(o_m_tdata[104:81]));
            check_field("duty",        64'(e.duty),        64'(o_m_tdata[121:105]));
            check_field("armed",       64'(e.armed),       64'(o_m_tdata[122]));
            check_field("timed_out",   64'(e.timed_out),   64'(o_m_tdata[123]));
        end
    endtask

    // receiver: check on each handshake, then pick ready for the next edge
    initial begin : result_sink
        bit stall;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) check_reading();
            if (holdoff_left > 0) begin
                holdoff_left--;
                stall = 1'b1;
            end else begin
                stall = !calm_mode && ($urandom_range(99) < 36);
            end
            i_m_tready <= !stall;
        end
    end

    // reset defaults: arming, glitch at the limit, speed from a zero period, timeout
    task automatic test_defaults();
        send_event(ACT_OVERFLOW, 16'h0101, 1'b1);   // overflow while disarmed, ignored
        send_event(ACT_CAPTURE, 16'h00ff, 1'b0);    // low pin while disarmed, ignored
        send_event(ACT_CAPTURE, 16'h1234, 1'b1);    // arms
        send_event(ACT_CAPTURE, 16'd500, 1'b1);     // rising edge, old period is zero
        send_event(ACT_CAPTURE, 16'hffff, 1'b0);    // high length at full count
        send_event(ACT_CAPTURE, 16'd20, 1'b1);      // width equal to the glitch limit
        send_event(ACT_CAPTURE, 16'd21, 1'b1);      // just above the limit
        repeat (4) send_event(ACT_OVERFLOW, 16'h0000, 1'b0);
        send_event(ACT_CAPTURE, 16'hffff, 1'b0);    // four overflows folded in
        send_event(ACT_CAPTURE, 16'h0000, 1'b1);
        repeat (5) send_event(ACT_OVERFLOW, 16'hffff, 1'b1);  // fifth one times out
        send_event(ACT_CAPTURE, 16'h8000, 1'b0);    // disarmed again
    endtask

    // register extremes, including values past the documented range
    task automatic test_register_extremes();
        // zero weight adds nothing, zero glitch limit, smallest nonzero numerator
        set_registers(24'd0, 24'd3, 24'd0, 24'd1);
        send_event(ACT_CAPTURE, 16'h5555, 1'b1);
        send_event(ACT_OVERFLOW, 16'h0000, 1'b0);
        send_event(ACT_OVERFLOW, 16'h0000, 1'b0);
        send_event(ACT_CAPTURE, 16'd0, 1'b0);       // zero width is still a glitch
        send_event(ACT_CAPTURE, 16'd1, 1'b1);
        send_event(ACT_CAPTURE, 16'd100, 1'b0);
        send_event(ACT_CAPTURE, 16'd7, 1'b1);
        // zero limit times out on the very first overflow
        set_registers(24'd65536, 24'd0, 24'd65535, 24'hffffff);
        send_event(ACT_OVERFLOW, 16'h0000, 1'b0);
        send_event(ACT_CAPTURE, 16'hffff, 1'b0);    // low pin while disarmed after the timeout, ignored
        // all-ones data: weight masks to its widest value
        set_registers(24'hffffff, 24'd15, 24'd0, 24'hffffff);
        repeat (8) send_event(ACT_OVERFLOW, 16'haaaa, 1'b1);
        send_event(ACT_CAPTURE, 16'hffff, 1'b1);
        send_event(ACT_CAPTURE, 16'h0001, 1'b0);
    endtask

    // mix of well-formed bursts and noise until the target of live words is reached
    task automatic run_bursts(int target);
        int start_count;
        int edges;
        int ovf;
        logic pin;
        logic [CNT_W-1:0] count;
        start_count = live_events;
        while (live_events - start_count < target) begin
            if ($urandom_range(99) < 15) begin
                send_event(1'($urandom_range(1)), CNT_W'($urandom_range(65535)),
                           1'($urandom_range(1)));
            end else begin
                if (!st_running)
                    send_event(ACT_CAPTURE, CNT_W'($urandom_range(65535)), 1'b1);
                edges = $urandom_range(12, 2);
                pin   = 1'($urandom_range(1));
                repeat (edges) begin
                    if (cfg_max_ovf > 1 && $urandom_range(99) < 40) begin
                        ovf = $urandom_range(cfg_max_ovf - 1, 1);
                        repeat (ovf) send_event(ACT_OVERFLOW, CNT_W'($urandom_range(65535)),
                                                1'($urandom_range(1)));
                    end
                    case ($urandom_range(9))
                        0:       count = CNT_W'($urandom_range(cfg_glitch)); // likely a glitch
                        1:       count = CNT_W'($urandom_range(65535));
                        default: count = (cfg_glitch < 16'hffff) ?
                                         CNT_W'($urandom_range(65535, cfg_glitch + 1)) :
                                         CNT_W'($urandom_range(65535));
                    endcase
                    send_event(ACT_CAPTURE, count, pin);
                    pin = ~pin;
                end
                // sometimes let the counter run out and disarm
                if ($urandom_range(99) < 30)
                    repeat (cfg_max_ovf) send_event(ACT_OVERFLOW,
                                                    CNT_W'($urandom_range(65535)),
                                                    1'($urandom_range(1)));
            end
        end
    endtask

    // receiver holds off for a long stretch while words keep coming, the block must stall
    task automatic test_output_backpressure();
        set_registers(24'd65535, 24'd5, 24'd20, 24'd7500000);
        @(posedge i_clk);
        holdoff_left = 300;
        run_bursts(40);
    endtask

    // random register settings, each followed by a run of random bursts
    task automatic test_random_bursts();
        logic [CFG_DATA_BITS-1:0] weight;
        logic [CFG_DATA_BITS-1:0] glitch;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(3))
                0:       weight = 24'd65535;
                1:       weight = 24'd65536;
                2:       weight = CFG_DATA_BITS'($urandom_range(65536, 1));
                default: weight = CFG_DATA_BITS'($urandom_range(4096, 1));
            endcase
            case ($urandom_range(9))
                0, 1:    glitch = CFG_DATA_BITS'($urandom_range(65535));
                2:       glitch = 24'd65535;
                default: glitch = CFG_DATA_BITS'($urandom_range(400));
            endcase
            set_registers(weight, CFG_DATA_BITS'($urandom_range(15, 1)), glitch,
                          CFG_DATA_BITS'($urandom_range(24'hffffff, 1)));
            // the first setting runs without any idling
            calm_mode = (phase == 0);
            run_bursts(265);
            calm_mode = 1'b0;
        end
    endtask

    // main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_random_bursts();
        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
